FILE: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: request and result
// payloads, request selectors and result status codes.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned REQ_W = 3;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned OCC_W = 7;

  // Request selectors
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DUMP       = 3'd4;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [VAL_W-1:0] push_value;
  } deq_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] item_value;
    logic                    has_item;
    logic                    last_of_run;
    logic [ST_W-1:0]         status;
    logic [OCC_W-1:0]        occupancy;
  } deq_rsp_t;

endpackage

FILE: sv/deq_out_fifo.sv
// ----------------------------------------------------------------------------
// deq_out_fifo
// Two-entry result queue that decouples the ring logic from the output
// handshake. The writer must only write when an entry is free.
// ----------------------------------------------------------------------------
module deq_out_fifo
  import deq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_valid_i,
  input  deq_rsp_t wr_data_i,
  output logic     rd_valid_o,
  input  logic     rd_ready_i,
  output deq_rsp_t rd_data_o,
  output logic [1:0] count_o
);

  deq_rsp_t   entry_q [2];
  logic       head_q, head_d;
  logic [1:0] cnt_q, cnt_d;
  logic       tail;
  logic       pop;

  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = entry_q[head_q];
  assign count_o    = cnt_q;
  assign pop        = rd_valid_o && rd_ready_i;
  assign tail       = head_q ^ cnt_q[0];

  always_comb begin
    head_d = head_q ^ pop;
    cnt_d  = cnt_q + {1'b0, wr_valid_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      entry_q[tail] <= wr_data_i;
    end
  end

endmodule

FILE: sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values held in a DEPTH-entry ring memory,
// described by a front index and an element count.
// ----------------------------------------------------------------------------
// Results: a push or pop result is written straight into the output queue;
//   dump elements first pass through the registered memory read port.
// Throughput: pushes and pops one per cycle while the output queue has room;
//   a dump holds off new requests until the single read port's last read lands.
// Reset: front index, count and control clear at once; the ring memory is
//   not cleared, since only occupied entries are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  deq_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output deq_rsp_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = IDX_W + 1;

  // Sequencer codes
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  // Ring storage: one write port, one registered read port
  logic [VAL_W-1:0] ring_mem [DEPTH];

  // Architectural state
  logic             state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Dump walker
  logic [IDX_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] left_q, left_d;
  logic             rd_pend_q;
  logic             rd_last_q;
  logic signed [VAL_W-1:0] rd_data_q;

  // Memory port controls
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_last;

  // Status result from a push, pop, empty dump or unused selector
  logic             st_wr;
  logic [ST_W-1:0]  st_code;

  // Output queue
  logic       fifo_wr;
  deq_rsp_t   fifo_wdata;
  logic [1:0] fifo_cnt;
  logic       fifo_pop;
  logic [2:0] occ_sum;
  logic       slot_free;
  logic       in_acc;

  // Ring arithmetic
  logic             full, empty;
  logic [IDX_W-1:0] front_dec, front_inc, rd_ptr_inc, back_addr;
  logic [SUM_W-1:0] back_sum;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  assign front_dec  = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc  = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign rd_ptr_inc = (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

  // front + count stays below 2*DEPTH, so one conditional subtract wraps it
  assign back_sum  = SUM_W'(front_q) + SUM_W'(count_q);
  assign back_addr = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(back_sum);

  // Credit check: queued results plus the read in flight, less the one
  // leaving this cycle, must leave an entry free for a new result.
  assign fifo_pop  = out_valid_o && out_ready_i;
  assign occ_sum   = {1'b0, fifo_cnt} + {2'b00, rd_pend_q} - {2'b00, fifo_pop};
  assign slot_free = (occ_sum < 3'd2);

  // Hold requests during a dump and until its last read lands, so results
  // of the next transaction never overtake dump data.
  assign in_ready_o = (state_q == ST_IDLE) && !rd_pend_q && slot_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    count_d  = count_q;
    rd_ptr_d = rd_ptr_q;
    left_d   = left_q;
    wr_en    = 1'b0;
    wr_addr  = back_addr;
    rd_en    = 1'b0;
    rd_addr  = rd_ptr_q;
    rd_last  = 1'b0;
    st_wr    = 1'b0;
    st_code  = ST_OK;

    if (in_acc) begin
      unique case (in_data_i.req_type)
        REQ_PUSH_FRONT: begin
          st_wr = 1'b1;
          if (full) begin
            st_code = ST_FULL;
          end else begin
            front_d = front_dec;
            wr_en   = 1'b1;
            wr_addr = front_dec;
            count_d = count_q + 1'b1;
          end
        end
        REQ_PUSH_BACK: begin
          st_wr = 1'b1;
          if (full) begin
            st_code = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = back_addr;
            count_d = count_q + 1'b1;
          end
        end
        REQ_POP_FRONT: begin
          st_wr = 1'b1;
          if (empty) begin
            st_code = ST_EMPTY;
          end else begin
            front_d = front_inc;
            count_d = count_q - 1'b1;
          end
        end
        REQ_POP_BACK: begin
          st_wr = 1'b1;
          if (empty) begin
            st_code = ST_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        REQ_DUMP: begin
          if (empty) begin
            // Single marker result with no item
            st_wr = 1'b1;
          end else begin
            // Issue the front read now, walk the rest in ST_DUMP
            rd_en   = 1'b1;
            rd_addr = front_q;
            rd_last = (count_q == CNT_W'(1));
            if (count_q != CNT_W'(1)) begin
              state_d  = ST_DUMP;
              rd_ptr_d = front_inc;
              left_d   = count_q - 1'b1;
            end
          end
        end
        default: begin
          // Unused selector: no operation, one ok result
          st_wr = 1'b1;
        end
      endcase
    end else if (state_q == ST_DUMP && slot_free) begin
      // Advance one element per cycle while the output queue has room
      rd_en    = 1'b1;
      rd_addr  = rd_ptr_q;
      rd_last  = (left_q == CNT_W'(1));
      rd_ptr_d = rd_ptr_inc;
      left_d   = left_q - 1'b1;
      if (left_q == CNT_W'(1)) begin
        state_d = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      rd_ptr_q  <= '0;
      left_q    <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      rd_ptr_q  <= rd_ptr_d;
      left_q    <= left_d;
      rd_pend_q <= rd_en;
    end
  end

  // Writes only happen on accepted pushes and reads only after them, so a
  // read never overlaps a write to the same entry and needs no bypass.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= in_data_i.push_value;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_addr];
    end
    rd_last_q <= rd_last;
  end

  // Dump data and status results never arrive in the same cycle
  always_comb begin
    fifo_wr = rd_pend_q || st_wr;
    if (rd_pend_q) begin
      fifo_wdata.item_value  = rd_data_q;
      fifo_wdata.has_item    = 1'b1;
      fifo_wdata.last_of_run = rd_last_q;
      fifo_wdata.status      = ST_OK;
      fifo_wdata.occupancy   = OCC_W'(count_q);
    end else begin
      fifo_wdata.item_value  = '0;
      fifo_wdata.has_item    = 1'b0;
      fifo_wdata.last_of_run = 1'b1;
      fifo_wdata.status      = st_code;
      fifo_wdata.occupancy   = OCC_W'(count_d);
    end
  end

  deq_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fifo_wr),
    .wr_data_i  (fifo_wdata),
    .rd_valid_o (out_valid_o),
    .rd_ready_i (out_ready_i),
    .rd_data_o  (out_data_o),
    .count_o    (fifo_cnt)
  );

endmodule

FILE: sv/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks on the double-ended queue, attached by bind.
// ----------------------------------------------------------------------------
module deq_checker
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input deq_req_t in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input deq_rsp_t out_data_o
);

  // A stalled request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("request changed while stalled");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Dumped elements always carry ok status
  a_item_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.has_item |-> out_data_o.status == ST_OK)
    else $error("dumped element with non-ok status");

  // A result without an item is a single, final, zero-valued result
  a_noitem_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_item |->
      out_data_o.last_of_run && out_data_o.item_value == '0)
    else $error("status result not final or not zero");

  // Occupancy never exceeds the ring size
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.occupancy <= OCC_W'(DEPTH))
    else $error("occupancy beyond depth");

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
